// ----- rtl/u8vcc_pkg.sv -----
// ----------------------------------------------------------------------------
// u8vcc_pkg: shared types and constants of the UTF-8 code point counter
// Holds the decoder state record and the continuation window codes.
// ----------------------------------------------------------------------------
package u8vcc_pkg;

	// Allowed range of the next continuation byte.
	localparam logic [1:0] WIN_ANY   = 2'd0;  // 80-BF
	localparam logic [1:0] WIN_A0_BF = 2'd1;  // after E0
	localparam logic [1:0] WIN_90_BF = 2'd2;  // after F0
	localparam logic [1:0] WIN_80_8F = 2'd3;  // after F4

	// Byte that ends a string.
	localparam logic [7:0] BYTE_NUL = 8'h00;

	// Width of the count field in a result item.
	localparam int unsigned OUT_COUNT_W = 32;

	// Sequence decoder state.
	typedef struct packed {
		logic [1:0] pending;  // continuation bytes still expected
		logic [1:0] window;   // allowed range of the next continuation byte
		logic       err;      // an error was found in this string
	} dec_state_t;

	// Decoder outputs for one byte.
	typedef struct packed {
		dec_state_t nxt;      // state after this byte
		logic       bump;     // one more code point is complete
		logic       bad;      // string ends malformed (valid on NUL only)
		logic       eos;      // byte is the NUL that ends the string
	} dec_result_t;

	localparam dec_state_t DEC_IDLE = '{pending: 2'd0, window: WIN_ANY, err: 1'b0};

endpackage

// ----- rtl/u8vcc_step.sv -----
// ----------------------------------------------------------------------------
// u8vcc_step: UTF-8 sequence decoder for one byte
// Computes the next decoder state, the count increment and the end-of-string
// verdict from the current state and one byte.
// ----------------------------------------------------------------------------
module u8vcc_step
	import u8vcc_pkg::*;
(
	input  logic [7:0]  data_byte,
	input  dec_state_t  cur,
	output dec_result_t res
);

	logic in_win;

	// Check the byte against the window set by the lead byte.
	always_comb begin
		case (cur.window)
			WIN_A0_BF: in_win = (data_byte >= 8'hA0) && (data_byte <= 8'hBF);
			WIN_90_BF: in_win = (data_byte >= 8'h90) && (data_byte <= 8'hBF);
			WIN_80_8F: in_win = (data_byte >= 8'h80) && (data_byte <= 8'h8F);
			default:   in_win = (data_byte >= 8'h80) && (data_byte <= 8'hBF);
		endcase
	end

	// Next state for lead bytes, continuation bytes and the terminating NUL.
	always_comb begin
		res.nxt  = cur;
		res.bump = 1'b0;
		res.eos  = (data_byte == BYTE_NUL);
		res.bad  = cur.err || (cur.pending != 2'd0);
		if (res.eos) begin
			res.nxt = DEC_IDLE;
		end else if (cur.err) begin
			// Bytes after an error are ignored until the NUL.
			res.nxt = cur;
		end else if (cur.pending == 2'd0) begin
			if (data_byte <= 8'h7F) begin
				res.bump = 1'b1;
			end else if ((data_byte >= 8'hC2) && (data_byte <= 8'hDF)) begin
				res.nxt.pending = 2'd1;
				res.nxt.window  = WIN_ANY;
			end else if ((data_byte >= 8'hE0) && (data_byte <= 8'hEF)) begin
				res.nxt.pending = 2'd2;
				res.nxt.window  = (data_byte == 8'hE0) ? WIN_A0_BF : WIN_ANY;
			end else if ((data_byte >= 8'hF0) && (data_byte <= 8'hF4)) begin
				res.nxt.pending = 2'd3;
				if (data_byte == 8'hF0) begin
					res.nxt.window = WIN_90_BF;
				end else if (data_byte == 8'hF4) begin
					res.nxt.window = WIN_80_8F;
				end else begin
					res.nxt.window = WIN_ANY;
				end
			end else begin
				res.nxt.err = 1'b1;
			end
		end else if (in_win) begin
			res.nxt.pending = cur.pending - 2'd1;
			res.nxt.window  = WIN_ANY;
			res.bump        = (cur.pending == 2'd1);
		end else begin
			res.nxt.err = 1'b1;
		end
	end

endmodule

// ----- rtl/utf8_validating_char_counter_unit.sv -----
// ----------------------------------------------------------------------------
// utf8_validating_char_counter_unit: UTF-8 validator and code point counter
// A result item is registered when its NUL byte leaves the input register.
// Throughput: one byte per cycle; the input register stalls only when a NUL
// waits for a full result register. The decoder state update sets the rate.
// Reset clears the input stage, the decoder state, the count and the result.
// ----------------------------------------------------------------------------
module utf8_validating_char_counter_unit
	import u8vcc_pkg::*;
#(
	parameter int unsigned COUNT_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // [31:0] char_count, [32] malformed, zero pad
);

	logic [7:0]             byte_s1;
	logic                   valid_s1;
	dec_state_t             state_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic [OUT_COUNT_W-1:0] count_sat;
	logic [OUT_COUNT_W-1:0] res_count_q;
	logic                   res_bad_q;
	logic                   res_valid_q;
	dec_result_t            dec;
	logic                   advance_s1;
	logic                   out_free;

	// Decode the byte held in the input register.
	u8vcc_step u_step (
		.data_byte (byte_s1),
		.cur       (state_q),
		.res       (dec)
	);

	// A NUL needs a free result register; any other byte always moves on.
	assign out_free   = !res_valid_q || m_tready;
	assign advance_s1 = valid_s1 && (!dec.eos || out_free);
	assign s_tready   = !valid_s1 || advance_s1;

	// Narrow the running count to the result field, saturating.
	generate
		if (COUNT_WIDTH > OUT_COUNT_W) begin : g_sat
			assign count_sat = (|count_q[COUNT_WIDTH-1:OUT_COUNT_W]) ?
				{OUT_COUNT_W{1'b1}} : count_q[OUT_COUNT_W-1:0];
		end else begin : g_ext
			assign count_sat = OUT_COUNT_W'(count_q);
		end
	endgenerate

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	// Decoder state and saturating code point count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DEC_IDLE;
			count_q <= '0;
		end else if (advance_s1) begin
			state_q <= dec.nxt;
			if (dec.eos) begin
				count_q <= '0;
			end else if (dec.bump && !(&count_q)) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance_s1 && dec.eos) begin
			res_valid_q <= 1'b1;
		end else if (m_tready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && dec.eos) begin
			res_count_q <= count_sat;
			res_bad_q   <= dec.bad;
		end
	end

	assign m_tvalid = res_valid_q;
	assign m_tdata  = {7'd0, res_bad_q, res_count_q};

	// A NUL that leaves the input register produces a result next cycle.
	a_nul_result: assert property (@(posedge clk) disable iff (!arst_n)
		(advance_s1 && dec.eos) |=> res_valid_q)
		else $error("NUL did not produce a result item");

	// The decoder state is idle right after a string ends.
	a_nul_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance_s1 && dec.eos) |=> (state_q == DEC_IDLE) && (count_q == '0))
		else $error("state not cleared after end of string");

	// A restricted window exists only while two or three bytes are pending.
	a_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.window != WIN_ANY) |-> (state_q.pending == 2'd2 || state_q.pending == 2'd3))
		else $error("restricted window without a multi-byte sequence");

	// The count never drops except at the end of a string.
	a_count_mono: assert property (@(posedge clk) disable iff (!arst_n)
		!(advance_s1 && dec.eos) |=> (count_q >= $past(count_q)))
		else $error("code point count decreased");

	// An overflowing result register would lose an item.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !m_tready) |-> !(advance_s1 && dec.eos))
		else $error("result overwritten while waiting");

endmodule
